>>> hdl/pscr_pkg.sv
// Shared types and constants for the clamped, ramped PID step block.
// No dependencies; every other file in hdl/ imports this package.
package pscr_pkg;

    localparam int DataW   = 32;
    localparam int GainW   = 31;
    localparam int DiffW   = 33;
    localparam int CfgIdxW = 3;
    localparam int TermW   = 48;

    typedef enum logic [CfgIdxW-1:0] {
        REG_KP       = 3'd0,
        REG_KI       = 3'd1,
        REG_KD       = 3'd2,
        REG_OUT_LOW  = 3'd3,
        REG_OUT_HIGH = 3'd4,
        REG_RAMP     = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [GainW-1:0]        kp;
        logic [GainW-1:0]        ki;
        logic [GainW-1:0]        kd;
        logic signed [DataW-1:0] out_low;
        logic signed [DataW-1:0] out_high;
        logic [GainW-1:0]        ramp_step;
    } cfg_t;

    // One classified step as it travels from the front end to the back end.
    typedef struct packed {
        logic signed [DiffW-1:0] error;
        logic signed [DiffW-1:0] meas_delta;
    } step_t;

endpackage

>>> hdl/pscr_front.sv
// Front end: accepts input beats, forms the error and the measurement change.
// Depends on pscr_pkg; feeds pscr_queue.
module pscr_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [63:0]         s_tdata,
    input  logic                q_full,
    output logic                q_push,
    output pscr_pkg::step_t     q_data
);
    import pscr_pkg::*;

    logic signed [DataW-1:0] prev_meas_reg;
    logic signed [DataW-1:0] prev_meas_next;
    logic signed [DataW-1:0] meas;
    logic signed [DataW-1:0] target;
    logic                    accept;

    assign meas     = s_tdata[31:0];
    assign target   = s_tdata[63:32];
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = accept;

    // Both differences are exact in 33 bits.
    assign q_data.error      = {target[DataW-1], target} - {meas[DataW-1], meas};
    assign q_data.meas_delta = {meas[DataW-1], meas} - {prev_meas_reg[DataW-1], prev_meas_reg};

    assign prev_meas_next = accept ? meas : prev_meas_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_meas_reg <= '0;
        end else begin
            prev_meas_reg <= prev_meas_next;
        end
    end

endmodule

>>> hdl/pscr_queue.sv
// Short first-in first-out queue of classified steps between front and back.
// Depends on pscr_pkg for the entry type.
module pscr_queue #(
    parameter int DEPTH = 4
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  pscr_pkg::step_t push_data,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output pscr_pkg::step_t pop_data
);
    import pscr_pkg::*;

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);

    step_t           mem_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign full     = (count_reg == CntW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CntW'(DEPTH))
        else $error("queue count exceeds depth");
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("push into a full queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> !pop)
        else $error("pop from an empty queue");
`endif

endmodule

>>> hdl/pscr_back.sv
// Back end: gain products, integrator update, sum with saturation, ramp limit.
// Depends on pscr_pkg; pops steps from pscr_queue and drives the result channel.
module pscr_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  pscr_pkg::cfg_t  cfg,
    input  logic            q_empty,
    input  pscr_pkg::step_t q_data,
    output logic            q_pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [31:0]     m_tdata
);
    import pscr_pkg::*;

    localparam int AccW = TermW + 1;
    localparam int SumW = TermW + 3;

    logic en;

    // Stage 1: three products, each floored to Q32.16.
    logic signed [63:0]      prod_p, prod_i, prod_d;
    logic                    s1_valid_reg;
    logic signed [TermW-1:0] s1_p_reg, s1_i_reg, s1_d_reg;

    // Stage 2: integrator update, negated derivative term.
    logic signed [AccW-1:0]  acc, low_ext, high_ext;
    logic signed [DataW-1:0] integ_reg, integ_next;
    logic                    s2_valid_reg;
    logic signed [TermW-1:0] s2_p_reg;
    logic signed [AccW-1:0]  s2_d_reg;

    // Stage 3: sum of the terms, saturated to 32 bits.
    logic signed [SumW-1:0]  sum;
    logic signed [DataW-1:0] sat;
    logic                    s3_valid_reg;
    logic signed [DataW-1:0] s3_drive_reg;

    // Stage 4: ramp limit against the previous output.
    logic signed [DiffW-1:0]   delta, ramp_ext;
    logic signed [DiffW:0]     ramp_up, ramp_dn;
    logic signed [DataW-1:0]   drive;
    logic signed [DataW-1:0]   prev_drive_reg;
    logic                      out_valid_reg;
    logic [DataW-1:0]          out_data_reg;

    // The whole back pipeline moves as one whenever the output slot is free.
    assign en    = !out_valid_reg || m_tready;
    assign q_pop = en && !q_empty;

    assign prod_p = $signed({1'b0, cfg.kp}) * q_data.error;
    assign prod_i = $signed({1'b0, cfg.ki}) * q_data.error;
    assign prod_d = $signed({1'b0, cfg.kd}) * q_data.meas_delta;

    assign acc      = {{(AccW-DataW){integ_reg[DataW-1]}}, integ_reg}
                    + {s1_i_reg[TermW-1], s1_i_reg};
    assign low_ext  = {{(AccW-DataW){cfg.out_low[DataW-1]}}, cfg.out_low};
    assign high_ext = {{(AccW-DataW){cfg.out_high[DataW-1]}}, cfg.out_high};

    // The upper limit is tested first, which settles crossed limits.
    always_comb begin
        if (acc > high_ext) begin
            integ_next = cfg.out_high;
        end else if (acc < low_ext) begin
            integ_next = cfg.out_low;
        end else begin
            integ_next = acc[DataW-1:0];
        end
    end

    assign sum = {{3{s2_p_reg[TermW-1]}}, s2_p_reg}
               + {{(SumW-DataW){integ_reg[DataW-1]}}, integ_reg}
               + {{2{s2_d_reg[AccW-1]}}, s2_d_reg};

    always_comb begin
        if (sum > SumW'(32'sh7FFF_FFFF)) begin
            sat = 32'sh7FFF_FFFF;
        end else if (sum < -SumW'(33'sh0_8000_0000)) begin
            sat = 32'sh8000_0000;
        end else begin
            sat = sum[DataW-1:0];
        end
    end

    assign delta    = {s3_drive_reg[DataW-1], s3_drive_reg}
                    - {prev_drive_reg[DataW-1], prev_drive_reg};
    assign ramp_ext = {2'b00, cfg.ramp_step};
    assign ramp_up  = {{2{prev_drive_reg[DataW-1]}}, prev_drive_reg} + {3'b000, cfg.ramp_step};
    assign ramp_dn  = {{2{prev_drive_reg[DataW-1]}}, prev_drive_reg} - {3'b000, cfg.ramp_step};

    always_comb begin
        drive = s3_drive_reg;
        if (cfg.ramp_step != '0) begin
            if (delta > ramp_ext) begin
                drive = ramp_up[DataW-1:0];
            end else if (delta < -ramp_ext) begin
                drive = ramp_dn[DataW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            integ_reg      <= '0;
            prev_drive_reg <= '0;
        end else if (en) begin
            s1_valid_reg  <= !q_empty;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
            if (s1_valid_reg) begin
                integ_reg <= integ_next;
            end
            if (s3_valid_reg) begin
                prev_drive_reg <= drive;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_p_reg     <= prod_p[63:16];
            s1_i_reg     <= prod_i[63:16];
            s1_d_reg     <= prod_d[63:16];
            s2_p_reg     <= s1_p_reg;
            s2_d_reg     <= -{s1_d_reg[TermW-1], s1_d_reg};
            s3_drive_reg <= sat;
            out_data_reg <= drive;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef ASSERT_OFF
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable({s1_valid_reg, s2_valid_reg, s3_valid_reg}))
        else $error("back pipeline moved while the output was stalled");
    a_integ_in_limits: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && s1_valid_reg && (cfg.out_low < cfg.out_high)) |=>
        (integ_reg >= $past(cfg.out_low) && integ_reg <= $past(cfg.out_high)))
        else $error("integrator left its limits");
    a_prev_tracks_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && s3_valid_reg) |=> (out_data_reg == prev_drive_reg))
        else $error("previous drive differs from the delivered drive");
`endif

endmodule

>>> hdl/pid_step_clamped_ramped_top.sv
// Top level of the PID step with integrator clamp and output ramp limit.
// Depends on pscr_pkg, pscr_front, pscr_queue and pscr_back.
//
//   Channel   Direction  Handshake            Payload
//   s_        in         s_tvalid / s_tready  s_tdata[31:0] measurement, [63:32] target
//   m_        out        m_tvalid / m_tready  m_tdata[31:0] drive
//   cfg_      in         cfg_wr_en            cfg_index selects the register, cfg_wdata
//
// One beat is accepted per cycle and one result beat leaves per cycle when the output
// is not stalled. An accepted beat is written into the step queue at the accepting
// edge, is read from it and then passes four back-end stages (products, integrator,
// sum with saturation, ramp limit), the last of which holds the output beat. The
// integrator and ramp recurrences each close within a single stage, which is what
// allows a new beat every cycle.
// Reset is synchronous and active low; it clears the integrator, the stored
// measurement and drive, and restores the register defaults.
// A stalled output freezes the back end; the queue keeps accepting input until full.
module pid_step_clamped_ramped_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // [31:0] measurement, [63:32] target
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] drive
    // Register write port.
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);
    import pscr_pkg::*;

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    step_t push_data;
    step_t pop_data;
    logic  q_push, q_pop, q_full, q_empty;

    // Register writes. Gains and ramp step keep their low 31 bits; an index past the
    // last register is dropped.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_KP:       cfg_next.kp        = cfg_wdata[GainW-1:0];
                REG_KI:       cfg_next.ki        = cfg_wdata[GainW-1:0];
                REG_KD:       cfg_next.kd        = cfg_wdata[GainW-1:0];
                REG_OUT_LOW:  cfg_next.out_low   = cfg_wdata;
                REG_OUT_HIGH: cfg_next.out_high  = cfg_wdata;
                REG_RAMP:     cfg_next.ramp_step = cfg_wdata[GainW-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kp        <= '0;
            cfg_reg.ki        <= '0;
            cfg_reg.kd        <= '0;
            cfg_reg.out_low   <= -32'sd65536;
            cfg_reg.out_high  <= 32'sd65536;
            cfg_reg.ramp_step <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    pscr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (push_data)
    );

    pscr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (pop_data)
    );

    pscr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_data   (pop_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> bench/pscr_drive_checker.sv
// Checker for the clamped, ramped PID step: watches the register port and both streams,
// predicts every drive beat and compares it with what the block sends.
// Depends on pscr_pkg for the register codes and widths.
module pscr_drive_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [63:0]                  s_tdata,    // [31:0] measurement, [63:32] target
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [31:0]                  m_tdata,    // [31:0] drive
    input  logic                         cfg_wr_en,
    input  logic [pscr_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [31:0]                  cfg_wdata,
    output int                           fail_count,
    output int                           drive_pending
);
    import pscr_pkg::*;

    localparam longint DriveMax = 64'sd2147483647;
    localparam longint DriveMin = -DriveMax - 1;

    logic [GainW-1:0]        kp, ki, kd, ramp_step;
    logic signed [DataW-1:0] out_low, out_high;
    logic signed [DataW-1:0] integrator, last_meas, last_drive;
    logic [DataW-1:0]        expected_drive_q[$];
    logic [DataW-1:0]        want_drive;

    // One controller step. Products are exact in 64 bits and drop 16 fraction bits
    // with an arithmetic shift, which rounds toward minus infinity.
    function automatic logic [DataW-1:0] predict_drive(input logic signed [DataW-1:0] meas,
                                                       input logic signed [DataW-1:0] target);
        longint error, meas_delta, acc, total, step;
        error      = longint'(target) - longint'(meas);
        meas_delta = longint'(meas) - longint'(last_meas);
        acc = longint'(integrator) + ((longint'(ki) * error) >>> 16);
        // The upper limit is tested first, which matters when the limits cross.
        if (acc > longint'(out_high))
            acc = longint'(out_high);
        else if (acc < longint'(out_low))
            acc = longint'(out_low);
        integrator = acc[DataW-1:0];
        total = ((longint'(kp) * error) >>> 16) + acc - ((longint'(kd) * meas_delta) >>> 16);
        if (total > DriveMax)
            total = DriveMax;
        else if (total < DriveMin)
            total = DriveMin;
        step = longint'(ramp_step);
        if (step != 0) begin
            if (total - longint'(last_drive) > step)
                total = longint'(last_drive) + step;
            else if (total - longint'(last_drive) < -step)
                total = longint'(last_drive) - step;
        end
        last_meas  = meas;
        last_drive = total[DataW-1:0];
        return total[DataW-1:0];
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            kp         = '0;
            ki         = '0;
            kd         = '0;
            ramp_step  = '0;
            out_low    = -32'sd65536;
            out_high   = 32'sd65536;
            integrator = '0;
            last_meas  = '0;
            last_drive = '0;
            expected_drive_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_KP:       kp        = cfg_wdata[GainW-1:0];
                    REG_KI:       ki        = cfg_wdata[GainW-1:0];
                    REG_KD:       kd        = cfg_wdata[GainW-1:0];
                    REG_OUT_LOW:  out_low   = cfg_wdata;
                    REG_OUT_HIGH: out_high  = cfg_wdata;
                    REG_RAMP:     ramp_step = cfg_wdata[GainW-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_drive_q.push_back(predict_drive(s_tdata[31:0], s_tdata[63:32]));
            if (m_tvalid && m_tready) begin
                if (expected_drive_q.size() == 0) begin
                    $error("drive: no beat expected, got %0d", $signed(m_tdata));
                    fail_count++;
                end else begin
                    want_drive = expected_drive_q.pop_front();
                    if (m_tdata !== want_drive) begin
                        $error("drive: expected %0d, got %0d",
                               $signed(want_drive), $signed(m_tdata));
                        fail_count++;
                    end
                end
            end
        end
        drive_pending = expected_drive_q.size();
    end

endmodule

>>> bench/pid_step_clamped_ramped_top_test.sv
// Testbench top for the clamped, ramped PID step: clock, reset, register writes,
// input and output stream drivers, watchdog and verdict.
// Depends on pscr_pkg, the block itself and pscr_drive_checker.
module pid_step_clamped_ramped_top_test;
    import pscr_pkg::*;

    // Register indexes past the last real register; writes to them must be ignored.
    localparam logic [CfgIdxW-1:0] FirstSpareReg = 3'd6;
    localparam logic [CfgIdxW-1:0] LastSpareReg  = 3'd7;

    localparam logic [31:0] MostNegative = 32'h8000_0000;
    localparam logic [31:0] MostPositive = 32'h7fff_ffff;
    localparam logic [31:0] UnitValue    = 32'h0001_0000;
    localparam logic [31:0] GainMax      = 32'h7fff_ffff;

    localparam int PhaseCount    = 8;
    localparam int PhaseBeats    = 220;
    localparam int HoldCycles    = 400;
    localparam int SettleCycles  = 8;
    localparam int WatchdogLimit = 5000;

    logic               aclk;
    logic               aresetn   = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [63:0]        s_tdata   = '0;    // [31:0] measurement, [63:32] target
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [31:0]        m_tdata;           // [31:0] drive
    logic               cfg_wr_en = 1'b0;
    logic [CfgIdxW-1:0] cfg_index = REG_KP;
    logic [31:0]        cfg_wdata = '0;

    int fail_count;
    int drive_pending;

    // Idling controls. The percentages are the chance per cycle that the sender
    // withholds a beat or the receiver drops tready. hold_left is a forced stall
    // of the receiver that its own process counts down.
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    // The slowly moving process value and setpoint used by most random beats.
    logic signed [31:0] meas_now   = '0;
    logic signed [31:0] target_now = '0;

    pid_step_clamped_ramped_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    pscr_drive_checker drive_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .drive_pending (drive_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // The receiver changes tready on the falling edge only. A forced hold-off wins
    // over the random stalls, so the block backs up into its input queue.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready = 1'b0;
            hold_left--;
        end else begin
            m_tready = ($urandom_range(99) >= stall_pct);
        end
    end

    // The watchdog ends the run when no beat moves on either stream for too long.
    // Its limit is well beyond the forced hold-off and the pauses for register writes.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WatchdogLimit) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // All stimulus tasks start and end on a falling edge.
    task automatic write_reg(input logic [CfgIdxW-1:0] index, input logic [31:0] value);
        cfg_wr_en = 1'b1;
        cfg_index = index;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // Offers one beat after a random gap and holds it until the block takes it.
    // tvalid stays high afterwards so back-to-back beats see no bubble.
    task automatic send_beat(input logic [31:0] meas, input logic [31:0] target);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {target, meas};
        do
            @(posedge aclk);
        while (!s_tready);
        @(negedge aclk);
    endtask

    // Stops sending and waits until every expected drive beat has come back.
    // Every beat yields a result, so the block is idle once nothing is pending;
    // the extra cycles only let the outputs settle before the next register write.
    task automatic drain();
        s_tvalid = 1'b0;
        while (drive_pending != 0)
            @(negedge aclk);
        repeat (SettleCycles) @(negedge aclk);
    endtask

    // Idling controls change on a rising edge, away from the falling edge
    // where the receiver process reads them.
    task automatic set_idling(input int send_pct, input int rx_pct, input int hold);
        @(posedge aclk);
        send_idle_pct = send_pct;
        stall_pct     = rx_pct;
        hold_left     = hold;
        @(negedge aclk);
    endtask

    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(4))
            0:       return MostNegative;
            1:       return MostPositive;
            2:       return '0;
            3:       return '1;
            default: return UnitValue;
        endcase
    endfunction

    // Gains lean toward moderate values so the loop behaves like a real controller,
    // with zero, the maximum and values whose top bit the register must drop mixed in.
    function automatic logic [31:0] pick_gain();
        case ($urandom_range(9))
            0:          return '0;
            1, 2, 3, 4: return $urandom_range(0, 'h2_0000);
            5, 6:       return $urandom_range(0, 'h40_0000);
            7:          return $urandom;
            8:          return GainMax;
            default:    return '1;
        endcase
    endfunction

    task automatic program_phase(input int phase);
        logic [31:0] low_lim, high_lim, ramp;
        case (phase)
            0: begin
                // Everything at its extreme: all products and sums saturate often.
                write_reg(REG_KP, GainMax);
                write_reg(REG_KI, GainMax);
                write_reg(REG_KD, GainMax);
                write_reg(REG_OUT_LOW, MostNegative);
                write_reg(REG_OUT_HIGH, MostPositive);
                write_reg(REG_RAMP, '0);
            end
            1: begin
                // Zero gains with equal limits pin the integrator to one value,
                // and the smallest ramp step moves the drive one LSB at a time.
                write_reg(REG_KP, '0);
                write_reg(REG_KI, '0);
                write_reg(REG_KD, '0);
                write_reg(REG_OUT_LOW, 32'h0000_1000);
                write_reg(REG_OUT_HIGH, 32'h0000_1000);
                write_reg(REG_RAMP, 32'd1);
            end
            default: begin
                case ($urandom_range(19))
                    0, 1: begin
                        // Crossed or arbitrary limits.
                        low_lim  = $urandom;
                        high_lim = $urandom;
                    end
                    2, 3, 4: begin
                        low_lim  = MostNegative;
                        high_lim = MostPositive;
                    end
                    default: begin
                        low_lim  = -int'($urandom_range(0, 'h40_0000));
                        high_lim = $urandom_range(0, 'h40_0000);
                    end
                endcase
                case ($urandom_range(9))
                    0, 1, 2, 3: ramp = '0;
                    4, 5, 6:    ramp = $urandom_range(1, 'h2_0000);
                    7, 8:       ramp = $urandom;
                    default:    ramp = GainMax;
                endcase
                write_reg(REG_KP, pick_gain());
                write_reg(REG_KI, pick_gain());
                write_reg(REG_KD, pick_gain());
                write_reg(REG_OUT_LOW, low_lim);
                write_reg(REG_OUT_HIGH, high_lim);
                write_reg(REG_RAMP, ramp);
            end
        endcase
    endtask

    // Most beats follow a measurement that drifts in small steps around a setpoint
    // that jumps now and then, which keeps the integrator and ramp in play. The
    // rest are fully random words and the extremes of both fields.
    task automatic send_random_beat();
        case ($urandom_range(9))
            0: send_beat($urandom, $urandom);
            1: send_beat(pick_extreme(), pick_extreme());
            default: begin
                if ($urandom_range(19) == 0)
                    target_now = $signed($urandom) >>> $urandom_range(0, 16);
                meas_now = meas_now + (int'($urandom_range(0, 'h4_0000)) - 'h2_0000);
                send_beat(meas_now, target_now);
            end
        endcase
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Register defaults: all gains zero, so the drive must stay at zero.
        send_beat('0, '0);
        send_beat(MostNegative, MostPositive);
        drain();

        // Writes to spare indexes change nothing; the top bit of a gain is dropped.
        write_reg(FirstSpareReg, '1);
        write_reg(LastSpareReg, '1);
        write_reg(REG_KP, 32'h8001_0000);
        write_reg(REG_KI, 32'h0000_4000);
        write_reg(REG_KD, 32'h0002_0000);
        write_reg(REG_OUT_LOW, 32'hfffd_0000);
        write_reg(REG_OUT_HIGH, 32'h0003_0000);

        // Integrator hits the upper limit, falls back, then hits the lower limit.
        send_beat('0, 32'h0010_0000);
        send_beat('0, 32'hfff0_0000);
        send_beat('0, 32'hfff0_0000);
        // A jump in the measurement drives the derivative term, then the
        // widest errors push the sum into saturation on both sides.
        send_beat(32'h0005_0000, 32'h0005_0000);
        send_beat(MostPositive, MostNegative);
        send_beat(MostNegative, MostPositive);
        send_beat(MostPositive, MostPositive);
        send_beat(MostNegative, MostNegative);
        send_beat('1, '0);
        drain();

        // Crossed limits: the upper limit is checked first, then the lower one.
        write_reg(REG_OUT_LOW, 32'h0002_0000);
        write_reg(REG_OUT_HIGH, 32'hfffe_0000);
        send_beat('0, 32'h0010_0000);
        send_beat('0, 32'hfff0_0000);
        send_beat('0, '0);
        drain();

        // Ramp limiting in both directions.
        write_reg(REG_OUT_LOW, 32'hfffd_0000);
        write_reg(REG_OUT_HIGH, 32'h0003_0000);
        write_reg(REG_RAMP, 32'h0000_8000);
        send_beat('0, 32'h0010_0000);
        send_beat('0, 32'h0010_0000);
        send_beat('0, 32'hfff0_0000);
        send_beat('0, '0);
        drain();

        // Largest gains, widest limits and the largest ramp step.
        write_reg(REG_KP, GainMax);
        write_reg(REG_KI, GainMax);
        write_reg(REG_KD, GainMax);
        write_reg(REG_OUT_LOW, MostNegative);
        write_reg(REG_OUT_HIGH, MostPositive);
        write_reg(REG_RAMP, GainMax);
        send_beat(MostPositive, MostNegative);
        send_beat(MostNegative, MostPositive);
        send_beat(MostNegative, MostNegative);
        send_beat(MostPositive, MostPositive);
        drain();

        // Random phases, each with fresh register settings and one idling pattern.
        // Phase four runs with no idling and a long receiver hold-off while the
        // sender keeps offering beats, so the input queue fills and stalls.
        for (int phase = 0; phase < PhaseCount; phase++) begin
            program_phase(phase);
            case (phase % 4)
                0:       set_idling(0, 0, (phase == 4) ? HoldCycles : 0);
                1:       set_idling(87, 0, 0);
                2:       set_idling(0, 87, 0);
                default: set_idling(34, 34, 0);
            endcase
            repeat (PhaseBeats) send_random_beat();
            drain();
        end

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
